/* hw/rtl/vdi_pkg.sv */
// Shared constants and types of the vertex dedup indexer.
// Used by vdi_cell and vertex_dedup_indexer; depends on nothing else.
package vdi_pkg;

  localparam int MAX_VERTICES = 1024;

  // The table is spread over a row of cells, each holding one bank of rows.
  localparam int NUM_CELLS = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int ROWS      = (MAX_VERTICES + NUM_CELLS - 1) / NUM_CELLS;

  localparam int CELL_W = $clog2(NUM_CELLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCNT_W = $clog2(ROWS + 1);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int VIDX_W = 10;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [5:0]         tex_u;
    logic [5:0]         tex_v;
    logic [2:0]         face_code;
    logic [7:0]         texture_id;
  } vertex_t;

  // Search token that walks down the cell chain, one per table row.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
  } token_t;

  // Next free slot of the table: filled rows and cells used in the last row.
  typedef struct packed {
    logic [RCNT_W-1:0] row;
    logic [CELL_W-1:0] col;
  } fill_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] col;
    vertex_t           data;
  } wr_t;

endpackage

/* hw/rtl/vdi_cell.sv */
// One cell of the search chain: a bank of stored vertices and a two-stage compare.
// Depends on vdi_pkg.
module vdi_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [vdi_pkg::CELL_W-1:0] cell_id,
  input  vdi_pkg::vertex_t          key,
  input  vdi_pkg::fill_t            fill,
  input  vdi_pkg::wr_t              wr,
  input  vdi_pkg::token_t           tok_in,
  output vdi_pkg::token_t           tok_out
);
  import vdi_pkg::*;

  vertex_t mem [ROWS];
  vertex_t rd_data_r;
  token_t  a_tok_r;
  token_t  b_tok_r;
  token_t  b_tok_nxt;
  logic    slot_used;
  logic    hit;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.col == cell_id)) begin
      mem[wr.row] <= wr.data;
    end
    rd_data_r <= mem[tok_in.row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r <= '0;
      b_tok_r <= '0;
    end else begin
      a_tok_r <= tok_in;
      b_tok_r <= b_tok_nxt;
    end
  end

  // Only slots below the fill position hold written vertices.
  always_comb begin
    slot_used = (RCNT_W'(a_tok_r.row) < fill.row) ||
                ((RCNT_W'(a_tok_r.row) == fill.row) && (cell_id < fill.col));
    hit       = slot_used && (rd_data_r == key);
    b_tok_nxt = a_tok_r;
    // An earlier cell of the same row already holds the lower index.
    if (!a_tok_r.found && hit) begin
      b_tok_nxt.found = 1'b1;
      b_tok_nxt.idx   = a_tok_r.base + IDX_W'(cell_id);
    end
  end

  assign tok_out = b_tok_r;

endmodule

/* hw/rtl/vertex_dedup_indexer.sv */
// Vertex dedup indexer: sequencer, fill tracking and the chain of search cells.
// One row enters the 32-cell chain per cycle, and each cell adds a registered bank read
// and a compare stage; on an empty table no row is issued. busy is high until the result
// strobe, so a new vertex is not taken until the last one has its result; the receiver
// cannot stall.
// Synchronous active-low reset empties the table by clearing the fill position and count; stored vertices stay.
module vertex_dedup_indexer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_start_mesh,
  input  logic signed [23:0]        in_pos_x,
  input  logic signed [23:0]        in_pos_y,
  input  logic signed [23:0]        in_pos_z,
  input  logic [5:0]                in_tex_u,
  input  logic [5:0]                in_tex_v,
  input  logic [2:0]                in_face_code,
  input  logic [7:0]                in_texture_id,
  output logic                      out_valid,
  output logic [vdi_pkg::VIDX_W-1:0] out_vertex_index,
  output logic                      out_is_new,
  output logic                      out_overflow
);
  import vdi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            st_r, st_nxt;
  vertex_t           key_r, key_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  fill_t             fill_r, fill_nxt;
  logic [RCNT_W-1:0] issue_r, issue_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [RCNT_W-1:0] pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic              out_new_r, out_new_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              accept;
  logic              issue;
  logic              exit_beat;
  logic              done;
  logic              full;
  logic [RCNT_W-1:0] rows_used;
  wr_t               wr;
  token_t            chain [NUM_CELLS+1];

  assign accept    = start && (st_r == ST_IDLE);
  assign busy      = (st_r != ST_IDLE);
  assign rows_used = RCNT_W'(fill_r.row + RCNT_W'(fill_r.col != '0));
  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign issue     = (st_r == ST_SCAN) && (issue_r < rows_used);
  assign exit_beat = chain[NUM_CELLS].valid;
  assign done      = (st_r == ST_SCAN) && (issue_r == rows_used) && (pend_r == '0);

  always_comb begin
    chain[0].valid = issue;
    chain[0].found = 1'b0;
    chain[0].row   = issue_r[ROW_W-1:0];
    chain[0].base  = base_r;
    chain[0].idx   = '0;
  end

  always_comb begin
    wr.en   = done && !found_r && !full;
    wr.row  = fill_r.row[ROW_W-1:0];
    wr.col  = fill_r.col;
    wr.data = key_r;
  end

  generate
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      vdi_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_id (CELL_W'(k)),
        .key     (key_r),
        .fill    (fill_r),
        .wr      (wr),
        .tok_in  (chain[k]),
        .tok_out (chain[k+1])
      );
    end
  endgenerate

  always_comb begin
    st_nxt        = st_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    issue_nxt     = issue_r;
    base_nxt      = base_r;
    pend_nxt      = RCNT_W'(pend_r + RCNT_W'(issue) - RCNT_W'(exit_beat));
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;

    if (issue) begin
      issue_nxt = RCNT_W'(issue_r + 1'b1);
      base_nxt  = IDX_W'(base_r + IDX_W'(NUM_CELLS));
    end

    // Rows leave the chain in order, so the first found token has the lowest index.
    if (exit_beat && chain[NUM_CELLS].found && !found_r) begin
      found_nxt   = 1'b1;
      hit_idx_nxt = chain[NUM_CELLS].idx;
    end

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt          = ST_SCAN;
          key_nxt.pos_x      = in_pos_x;
          key_nxt.pos_y      = in_pos_y;
          key_nxt.pos_z      = in_pos_z;
          key_nxt.tex_u      = in_tex_u;
          key_nxt.tex_v      = in_tex_v;
          key_nxt.face_code  = in_face_code;
          key_nxt.texture_id = in_texture_id;
          issue_nxt       = '0;
          base_nxt        = '0;
          pend_nxt        = '0;
          found_nxt       = 1'b0;
          if (in_start_mesh) begin
            count_nxt = '0;
            fill_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        if (done) begin
          st_nxt        = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_idx_nxt = VIDX_W'(hit_idx_r);
            out_new_nxt = 1'b0;
            out_ovf_nxt = 1'b0;
          end else if (full) begin
            out_idx_nxt = '0;
            out_new_nxt = 1'b0;
            out_ovf_nxt = 1'b1;
          end else begin
            out_idx_nxt = VIDX_W'(count_r);
            out_new_nxt = 1'b1;
            out_ovf_nxt = 1'b0;
            count_nxt   = CNT_W'(count_r + 1'b1);
            if (fill_r.col == CELL_W'(NUM_CELLS - 1)) begin
              fill_nxt.col = '0;
              fill_nxt.row = RCNT_W'(fill_r.row + 1'b1);
            end else begin
              fill_nxt.col = CELL_W'(fill_r.col + 1'b1);
            end
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      fill_r      <= '0;
      issue_r     <= '0;
      pend_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    base_r    <= base_nxt;
    hit_idx_r <= hit_idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_new_r <= out_new_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_is_new       = out_new_r;
  assign out_overflow     = out_ovf_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NUM_CELLS].valid |-> (st_r == ST_SCAN))
    else $error("search token left the chain outside a scan");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (full && !out_is_new && (out_vertex_index == '0)))
    else $error("overflow result while the table is not full");

  a_new_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new) |-> (out_vertex_index == VIDX_W'(count_r - 1'b1)))
    else $error("new vertex index does not match the fill count");

endmodule
